/* rtl/looping_countdown_timer_with_hold_top_assert.svh */
// Assertion macros for the looping countdown timer; empty when synthesized.
`ifndef LOOPING_COUNTDOWN_TIMER_WITH_HOLD_TOP_ASSERT_SVH
`define LOOPING_COUNTDOWN_TIMER_WITH_HOLD_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define LCT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("timer assertion failed");
// Property checked on every clock edge, reset included.
`define LCT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("timer assertion failed");
`else
`define LCT_ASSERT(lbl, clk, rstn, prop)
`define LCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/lct_pkg.sv */
// Shared types and codes of the looping countdown timer.
package lct_pkg;

	// Command codes carried by the input item.
	typedef enum logic [1:0] {
		FUNC_START   = 2'd0,
		FUNC_RESTART = 2'd1,
		FUNC_CANCEL  = 2'd2,
		FUNC_TICK    = 2'd3
	} func_e;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 2'd2;

	// Per-item status flags from the timer core.
	typedef struct packed {
		logic fired;
		logic running;
	} status_t;

endpackage

/* rtl/looping_countdown_timer_with_hold_top.sv */
// Top level of the looping countdown timer with hold.
//
// Usage:
//  - Input stream (s_*): one item per command. s_tuser carries the command
//    (start if idle, restart, cancel, tick); s_tdata carries tick_delta in
//    unsigned Q16.16, read only by tick.
//  - Output stream (m_*): exactly one result item per input item, in order.
//    m_tuser says the countdown fired; m_tdata holds elapsed_time (period
//    minus remaining at expiry, zero when not fired) and the running flag.
//  - Config channel (cfg_*): index 0 period_time, 1 loop_enable, 2 hold_time;
//    always ready. Write only while no item is in flight.
//  - Pipeline: an accepted item waits in the input register, is applied to
//    the timer state as it enters the result register, then shows on m_tvalid.
//  - Throughput: one item per cycle while m_tready is high; the state update
//    is one subtract, compare and reload between the input and result registers.
//  - Stall: a stalled result sits in the output register while one more item
//    is taken into the input register; only then does s_tready drop.
//  - Reset (arst_n low): timer idle, remaining time and hold cleared, all
//    config registers zero, both pipeline registers empty.
module looping_countdown_timer_with_hold_top #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((TIME_BITS+7)/8)*8-1:0]      s_tdata,   // [TIME_BITS-1:0] tick_delta
	input  logic [1:0]                          s_tuser,   // [1:0] func
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((TIME_BITS+9)/8)*8-1:0]      m_tdata,   // elapsed_time, running, zero pad
	output logic [0:0]                          m_tuser,   // [0] fired
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [TIME_BITS-1:0]                cfg_data
);
	import lct_pkg::*;

	`include "looping_countdown_timer_with_hold_top_assert.svh"

	localparam int unsigned OUT_W = ((TIME_BITS + 9) / 8) * 8;

	logic [TIME_BITS-1:0] period_time, hold_time;
	logic                 loop_enable;

	// input register
	logic                 s1_valid_q;
	func_e                s1_func_q;
	logic [TIME_BITS-1:0] s1_delta_q;

	// result register
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [TIME_BITS:0]   out_elapsed_q;

	status_t              core_status;
	logic [TIME_BITS:0]   core_elapsed;
	logic                 out_free, s1_adv, s_acc;

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	lct_cfg_regs #(.TIME_BITS(TIME_BITS)) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid && cfg_ready),
		.wr_index    (cfg_index),
		.wr_data     (cfg_data),
		.period_time (period_time),
		.loop_enable (loop_enable),
		.hold_time   (hold_time)
	);

	lct_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s1_adv),
		.func         (s1_func_q),
		.tick_delta   (s1_delta_q),
		.period_time  (period_time),
		.loop_enable  (loop_enable),
		.hold_time    (hold_time),
		.status       (core_status),
		.elapsed_time (core_elapsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			s1_func_q  <= func_e'(s_tuser);
			s1_delta_q <= s_tdata[TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_status_q  <= core_status;
			out_elapsed_q <= core_elapsed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q.fired;
	assign m_tdata  = {{(OUT_W-TIME_BITS-2){1'b0}}, out_status_q.running, out_elapsed_q};

	// an accepted item always lands in the input register
	`LCT_ASSERT(a_accept_loads, clk, arst_n, s_acc |=> s1_valid_q)
	// a result without expiry reports zero elapsed time
	`LCT_ASSERT(a_quiet_zero, clk, arst_n,
		(out_valid_q && !out_status_q.fired) |-> (out_elapsed_q == '0))
	// firing with looping off leaves the timer stopped
	`LCT_ASSERT(a_oneshot_stops, clk, arst_n,
		(s1_adv && core_status.fired && !loop_enable) |-> !core_status.running)
	// a clock edge under reset leaves the pipeline empty
	`LCT_ASSERT_ALWAYS(a_reset_empty, clk,
		!arst_n |=> (!s1_valid_q && !out_valid_q))

endmodule

/* rtl/lct_cfg_regs.sv */
// Configuration register file of the looping countdown timer.
module lct_cfg_regs #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lct_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [TIME_BITS-1:0]           wr_data,
	output logic [TIME_BITS-1:0]           period_time,
	output logic                           loop_enable,
	output logic [TIME_BITS-1:0]           hold_time
);
	import lct_pkg::*;

	logic [TIME_BITS-1:0] period_q;
	logic                 loop_q;
	logic [TIME_BITS-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			loop_q   <= 1'b0;
			hold_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_PERIOD_TIME: period_q <= wr_data;
				CFG_LOOP_ENABLE: loop_q   <= wr_data[0];
				CFG_HOLD_TIME:   hold_q   <= wr_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign period_time = period_q;
	assign loop_enable = loop_q;
	assign hold_time   = hold_q;

endmodule

/* rtl/lct_core.sv */
// Timer state and the combinational command/tick next-state update.
module lct_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  lct_pkg::func_e        func,
	input  logic [TIME_BITS-1:0]  tick_delta,
	input  logic [TIME_BITS-1:0]  period_time,
	input  logic                  loop_enable,
	input  logic [TIME_BITS-1:0]  hold_time,
	output lct_pkg::status_t      status,
	output logic [TIME_BITS:0]    elapsed_time
);
	import lct_pkg::*;

	// remaining time: two's complement, two bits above the time width
	localparam int unsigned RW = TIME_BITS + 2;

	logic [RW-1:0] remaining_q, remaining_n;
	logic          hold_q, hold_n;
	logic          active_q, active_n;

	logic [RW-1:0] period_ext;
	logic [RW-1:0] rem_sub;
	logic [RW-1:0] elapsed_full;
	logic          expired;

	assign period_ext   = {2'b00, period_time};
	assign rem_sub      = remaining_q - {2'b00, tick_delta};
	assign expired      = rem_sub[RW-1] | (rem_sub == '0);
	assign elapsed_full = period_ext - rem_sub;

	always_comb begin
		remaining_n  = remaining_q;
		hold_n       = hold_q;
		active_n     = active_q;
		status.fired = 1'b0;
		elapsed_time = '0;
		unique case (func)
			FUNC_START: begin
				if (!active_q) begin
					remaining_n = period_ext;
					hold_n      = 1'b0;
					active_n    = 1'b1;
				end
			end
			FUNC_RESTART: begin
				remaining_n = period_ext;
				hold_n      = 1'b0;
				active_n    = 1'b1;
			end
			FUNC_CANCEL: begin
				remaining_n = '0;
				hold_n      = 1'b0;
				active_n    = 1'b0;
			end
			FUNC_TICK: begin
				if (active_q) begin
					remaining_n = rem_sub;
					if (expired) begin
						if (hold_q) begin
							// end of hold: reload quietly
							hold_n      = 1'b0;
							remaining_n = period_ext;
						end else begin
							status.fired = 1'b1;
							elapsed_time = elapsed_full[TIME_BITS:0];
							if (!loop_enable) begin
								active_n = 1'b0;
							end else if (hold_time != '0) begin
								hold_n      = 1'b1;
								remaining_n = {2'b00, hold_time};
							end else begin
								hold_n      = 1'b0;
								remaining_n = period_ext;
							end
						end
					end
				end
			end
			default: ;
		endcase
		status.running = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			hold_q      <= 1'b0;
			active_q    <= 1'b0;
		end else if (step) begin
			remaining_q <= remaining_n;
			hold_q      <= hold_n;
			active_q    <= active_n;
		end
	end

endmodule
